/* rtl/tsa_pkg.sv */
// ============================================================================
// tsa_pkg
// Shared types, constants and the arctangent table for the solid angle block.
// ============================================================================
`default_nettype none

package tsa_pkg;

  localparam int CORDIC_STEPS  = 28;
  localparam int FRACTION_BITS = 30;
  localparam int NORM_BITS     = 60;
  localparam int COMP_W        = 32;
  localparam int NUM_COMP      = 9;
  localparam int IN_W          = COMP_W * NUM_COMP;
  localparam int OUT_W         = 32;
  localparam int WIDE_W        = 128;
  localparam int DEN_W         = 68;
  localparam int CORDIC_W      = 64;
  localparam int ANGLE_W       = 34;
  localparam int LEN_W         = 8;
  localparam int QUEUE_DEPTH   = 4;
  localparam int QPTR_W        = $clog2(QUEUE_DEPTH);
  localparam int QCNT_W        = QPTR_W + 1;

  localparam logic signed [ANGLE_W-1:0] PI_Q30 = 34'sd3373259426;

  typedef struct packed {
    logic                         zero;
    logic signed [CORDIC_W-1:0]   x;
    logic signed [CORDIC_W-1:0]   y;
    logic signed [ANGLE_W-1:0]    z;
  } tsa_item_t;

  function automatic logic signed [ANGLE_W-1:0] atan_q30(input int i);
    logic signed [ANGLE_W-1:0] r;
    case (i)
      0:  r = 34'sd843314857;
      1:  r = 34'sd497837829;
      2:  r = 34'sd263043837;
      3:  r = 34'sd133525159;
      4:  r = 34'sd67021687;
      5:  r = 34'sd33543516;
      6:  r = 34'sd16775851;
      7:  r = 34'sd8388437;
      8:  r = 34'sd4194283;
      9:  r = 34'sd2097149;
      10: r = 34'sd1048576;
      11: r = 34'sd524288;
      12: r = 34'sd262144;
      13: r = 34'sd131072;
      14: r = 34'sd65536;
      15: r = 34'sd32768;
      16: r = 34'sd16384;
      17: r = 34'sd8192;
      18: r = 34'sd4096;
      19: r = 34'sd2048;
      20: r = 34'sd1024;
      21: r = 34'sd512;
      22: r = 34'sd256;
      23: r = 34'sd128;
      24: r = 34'sd64;
      25: r = 34'sd32;
      26: r = 34'sd16;
      27: r = 34'sd8;
      28: r = 34'sd4;
      29: r = 34'sd2;
      30: r = 34'sd1;
      default: r = '0;
    endcase
    return r;
  endfunction

endpackage

`default_nettype wire

/* rtl/tsa_front.sv */
// ============================================================================
// tsa_front
// Request intake: triple product, denominator, magnitude normalisation and
// half-plane turn; pushes one prepared vector per request into the queue.
// ============================================================================
`default_nettype none

module tsa_front (
  input  wire logic                        clk,
  input  wire logic                        rst,
  input  wire logic                        s_tvalid,
  output logic                             s_tready,
  input  wire logic [tsa_pkg::IN_W-1:0]    s_tdata,
  input  wire logic                        q_full,
  output logic                             push,
  output tsa_pkg::tsa_item_t               item
);

  localparam int W   = tsa_pkg::WIDE_W;
  localparam int CW  = tsa_pkg::COMP_W;
  localparam int DW  = tsa_pkg::DEN_W;
  localparam int LW  = tsa_pkg::LEN_W;
  localparam int NST = 9;

  logic en;
  logic [NST-1:0] vld;

  assign en       = !q_full;
  assign s_tready = en;
  assign push     = vld[NST-1] & en;

  always_ff @(posedge clk) begin
    if (rst) begin
      vld <= '0;
    end else if (en) begin
      vld <= {vld[NST-2:0], s_tvalid};
    end
  end

  // stage 1: unpack
  logic signed [CW-1:0] a1 [3];
  logic signed [CW-1:0] b1 [3];
  logic signed [CW-1:0] c1 [3];

  always_ff @(posedge clk) begin
    if (en) begin
      for (int i = 0; i < 3; i++) begin
        a1[i] <= s_tdata[CW*i +: CW];
        b1[i] <= s_tdata[CW*(3+i) +: CW];
        c1[i] <= s_tdata[CW*(6+i) +: CW];
      end
    end
  end

  // stage 2: products
  logic signed [2*CW-1:0] pc [6];
  logic signed [2*CW-1:0] pd [9];
  logic signed [CW-1:0]   a2 [3];

  always_ff @(posedge clk) begin
    if (en) begin
      pc[0] <= b1[1] * c1[2];
      pc[1] <= c1[1] * b1[2];
      pc[2] <= b1[0] * c1[2];
      pc[3] <= c1[0] * b1[2];
      pc[4] <= b1[0] * c1[1];
      pc[5] <= c1[0] * b1[1];
      for (int i = 0; i < 3; i++) begin
        pd[i]   <= a1[i] * b1[i];
        pd[3+i] <= b1[i] * c1[i];
        pd[6+i] <= c1[i] * a1[i];
        a2[i]   <= a1[i];
      end
    end
  end

  // stage 3: cross product, partial dot sums
  logic signed [2*CW:0]   cr [3];
  logic signed [DW-1:0]   g  [3];
  logic signed [CW-1:0]   a3 [3];

  always_ff @(posedge clk) begin
    if (en) begin
      for (int j = 0; j < 3; j++) begin
        cr[j] <= {pc[2*j][2*CW-1], pc[2*j]} - {pc[2*j+1][2*CW-1], pc[2*j+1]};
        g[j]  <= {{(DW-2*CW){pd[3*j][2*CW-1]}},   pd[3*j]}
               + {{(DW-2*CW){pd[3*j+1][2*CW-1]}}, pd[3*j+1]}
               + {{(DW-2*CW){pd[3*j+2][2*CW-1]}}, pd[3*j+2]};
        a3[j] <= a2[j];
      end
    end
  end

  // stage 4: split multiplies of the triple product, denominator sum
  logic signed [2*CW:0] mh [3];
  logic signed [2*CW:0] ml [3];
  logic signed [DW-1:0] den4;

  always_ff @(posedge clk) begin
    if (en) begin
      for (int j = 0; j < 3; j++) begin
        mh[j] <= a3[j] * $signed(cr[j][2*CW:CW]);
        ml[j] <= a3[j] * $signed({1'b0, cr[j][CW-1:0]});
      end
      den4 <= (DW'(1) <<< (2 * tsa_pkg::FRACTION_BITS)) + g[0] + g[1] + g[2];
    end
  end

  // stage 5: recombine partial products
  logic signed [W-1:0] t5 [3];
  logic signed [W-1:0] den5;

  always_ff @(posedge clk) begin
    if (en) begin
      for (int j = 0; j < 3; j++) begin
        t5[j] <= ({{(W-2*CW-1){mh[j][2*CW]}}, mh[j]} <<< CW)
               + {{(W-2*CW-1){ml[j][2*CW]}}, ml[j]};
      end
      den5 <= {{(W-DW){den4[DW-1]}}, den4} <<< tsa_pkg::FRACTION_BITS;
    end
  end

  // stage 6: numerator
  logic signed [W-1:0] num6;
  logic signed [W-1:0] den6;

  always_ff @(posedge clk) begin
    if (en) begin
      num6 <= t5[0] - t5[1] + t5[2];
      den6 <= den5;
    end
  end

  // stage 7: magnitudes
  logic [W-1:0] magn7, magd7;
  logic         negn7, negd7, zero7;

  always_ff @(posedge clk) begin
    if (en) begin
      negn7 <= num6[W-1];
      negd7 <= den6[W-1];
      magn7 <= num6[W-1] ? W'(-num6) : W'(num6);
      magd7 <= den6[W-1] ? W'(-den6) : W'(den6);
      zero7 <= (num6 == '0) && (den6 == '0);
    end
  end

  // stage 8: per-chunk bit length
  localparam int CHUNK = 16;
  localparam int NCH   = W / CHUNK;

  function automatic logic [4:0] chunk_len(input logic [CHUNK-1:0] v);
    logic [4:0] n;
    n = '0;
    for (int k = 0; k < CHUNK; k++) begin
      if (v[k]) n = 5'(k + 1);
    end
    return n;
  endfunction

  logic [W-1:0] magn8, magd8;
  logic         negn8, negd8, zero8;
  logic [4:0]   clen8 [NCH];
  logic [NCH-1:0] nz8;

  always_ff @(posedge clk) begin
    if (en) begin
      magn8 <= magn7;
      magd8 <= magd7;
      negn8 <= negn7;
      negd8 <= negd7;
      zero8 <= zero7;
      for (int k = 0; k < NCH; k++) begin
        clen8[k] <= chunk_len(magn7[CHUNK*k +: CHUNK] | magd7[CHUNK*k +: CHUNK]);
        nz8[k]   <= |(magn7[CHUNK*k +: CHUNK] | magd7[CHUNK*k +: CHUNK]);
      end
    end
  end

  // stage 9: overall bit length
  logic [W-1:0]  magn9, magd9;
  logic          negn9, negd9, zero9;
  logic [LW-1:0] len9;
  logic [LW-1:0] len_sel;

  always_comb begin
    len_sel = '0;
    for (int k = 0; k < NCH; k++) begin
      if (nz8[k]) len_sel = LW'(CHUNK * k) + LW'(clen8[k]);
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      magn9 <= magn8;
      magd9 <= magd8;
      negn9 <= negn8;
      negd9 <= negd8;
      zero9 <= zero8;
      len9  <= len_sel;
    end
  end

  // normalise to a common length, then turn into the right half-plane
  function automatic logic signed [tsa_pkg::CORDIC_W-1:0] norm(
    input logic [W-1:0] mag, input logic neg, input logic [LW-1:0] len);
    logic [W-1:0] s;
    logic signed [tsa_pkg::CORDIC_W-1:0] r;
    if (len > LW'(tsa_pkg::NORM_BITS)) begin
      s = mag >> (len - LW'(tsa_pkg::NORM_BITS));
    end else begin
      s = mag << (LW'(tsa_pkg::NORM_BITS) - len);
    end
    r = {{(tsa_pkg::CORDIC_W-tsa_pkg::NORM_BITS){1'b0}}, s[tsa_pkg::NORM_BITS-1:0]};
    return neg ? -r : r;
  endfunction

  logic signed [tsa_pkg::CORDIC_W-1:0] xn, yn;

  always_comb begin
    xn = norm(magd9, negd9, len9);
    yn = norm(magn9, negn9, len9);
    item.zero = zero9;
    if (xn < 0) begin
      item.z = (yn >= 0) ? tsa_pkg::PI_Q30 : -tsa_pkg::PI_Q30;
      item.x = -xn;
      item.y = -yn;
    end else begin
      item.z = '0;
      item.x = xn;
      item.y = yn;
    end
  end

endmodule

`default_nettype wire

/* rtl/tsa_queue.sv */
// ============================================================================
// tsa_queue
// Short FIFO between the front end and the CORDIC back end.
// ============================================================================
`default_nettype none

module tsa_queue (
  input  wire logic               clk,
  input  wire logic               rst,
  input  wire logic               push,
  input  tsa_pkg::tsa_item_t      wdata,
  input  wire logic               pop,
  output tsa_pkg::tsa_item_t      rdata,
  output logic                    full,
  output logic                    avail
);

  tsa_pkg::tsa_item_t mem [tsa_pkg::QUEUE_DEPTH];
  logic [tsa_pkg::QPTR_W-1:0] wptr, rptr;
  logic [tsa_pkg::QCNT_W-1:0] count;

  assign full  = (count == tsa_pkg::QCNT_W'(tsa_pkg::QUEUE_DEPTH));
  assign avail = (count != '0);
  assign rdata = mem[rptr];

  always_ff @(posedge clk) begin
    if (push) begin
      mem[wptr] <= wdata;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wptr  <= '0;
      rptr  <= '0;
      count <= '0;
    end else begin
      if (push) wptr <= wptr + 1'b1;
      if (pop)  rptr <= rptr + 1'b1;
      case ({push, pop})
        2'b10:   count <= count + 1'b1;
        2'b01:   count <= count - 1'b1;
        default: count <= count;
      endcase
    end
  end

endmodule

`default_nettype wire

/* rtl/tsa_back.sv */
// ============================================================================
// tsa_back
// Unrolled vectoring CORDIC, one micro-rotation per stage, and output register.
// ============================================================================
`default_nettype none

module tsa_back (
  input  wire logic                     clk,
  input  wire logic                     rst,
  input  tsa_pkg::tsa_item_t            item,
  input  wire logic                     avail,
  output logic                          pop,
  output logic                          m_tvalid,
  input  wire logic                     m_tready,
  output logic [tsa_pkg::OUT_W-1:0]     m_tdata
);

  localparam int N  = tsa_pkg::CORDIC_STEPS;
  localparam int CW = tsa_pkg::CORDIC_W;
  localparam int AW = tsa_pkg::ANGLE_W;

  logic en;
  assign en  = !m_tvalid | m_tready;
  assign pop = avail & en;

  logic signed [CW-1:0] sx [N+1];
  logic signed [CW-1:0] sy [N+1];
  logic signed [AW-1:0] sz [N+1];
  logic                 szero [N+1];
  logic [N:0]           sv;

  always_ff @(posedge clk) begin
    if (rst) begin
      sv <= '0;
    end else if (en) begin
      sv <= {sv[N-1:0], pop};
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      sx[0]    <= item.x;
      sy[0]    <= item.y;
      sz[0]    <= item.z;
      szero[0] <= item.zero;
    end
  end

  for (genvar i = 0; i < N; i++) begin : g_step
    logic signed [CW-1:0] dx, dy;
    assign dx = sy[i] >>> i;
    assign dy = sx[i] >>> i;

    always_ff @(posedge clk) begin
      if (en) begin
        szero[i+1] <= szero[i];
        if (sy[i] >= 0) begin
          sx[i+1] <= sx[i] + dx;
          sy[i+1] <= sy[i] - dy;
          sz[i+1] <= sz[i] + tsa_pkg::atan_q30(i);
        end else begin
          sx[i+1] <= sx[i] - dx;
          sy[i+1] <= sy[i] + dy;
          sz[i+1] <= sz[i] - tsa_pkg::atan_q30(i);
        end
      end
    end
  end

  logic signed [AW-1:0] zr;
  assign zr = sz[N] + AW'(1);

  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid <= 1'b0;
    end else if (en) begin
      m_tvalid <= sv[N];
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      m_tdata <= szero[N] ? '0 : zr[tsa_pkg::OUT_W:1];
    end
  end

endmodule

`default_nettype wire

/* rtl/triangle_solid_angle.sv */
// ============================================================================
// triangle_solid_angle
// Solid angle of a spherical triangle: 2*atan2(det, 1 + pairwise dots).
// ============================================================================
// Input stream s_*: one request per triangle, nine Q2.30 components packed
// in s_tdata. Output stream m_*: one Q4.28 solid angle per request, in order.
// Throughput: one request per cycle while the receiver keeps m_tready high.
// Pipeline: 9 front stages, the queue write, the CORDIC input register,
// CORDIC_STEPS micro-rotation stages and the output register.
// The front end stalls only while its 4-entry queue is full; the CORDIC
// pipeline and output register hold when m_tvalid is high and m_tready low,
// and the queue absorbs requests in flight meanwhile.
// Both zero numerator and denominator give a result of zero.
// Reset (rst, synchronous) empties every stage and the queue; s_tready is
// high in the first cycle after reset.
// ============================================================================
`default_nettype none

module triangle_solid_angle (
  input  wire logic                       clk,
  input  wire logic                       rst,
  input  wire logic                       s_tvalid,
  output logic                            s_tready,
  // first_x, first_y, first_z, second_x, second_y, second_z,
  // third_x, third_y, third_z (32 bits each)
  input  wire logic [tsa_pkg::IN_W-1:0]   s_tdata,
  output logic                            m_tvalid,
  input  wire logic                       m_tready,
  // solid_angle
  output logic [tsa_pkg::OUT_W-1:0]       m_tdata
);

  tsa_pkg::tsa_item_t witem, ritem;
  logic push, pop, full, avail;

  tsa_front u_front (
    .clk      (clk),
    .rst      (rst),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tdata  (s_tdata),
    .q_full   (full),
    .push     (push),
    .item     (witem)
  );

  tsa_queue u_queue (
    .clk   (clk),
    .rst   (rst),
    .push  (push),
    .wdata (witem),
    .pop   (pop),
    .rdata (ritem),
    .full  (full),
    .avail (avail)
  );

  tsa_back u_back (
    .clk      (clk),
    .rst      (rst),
    .item     (ritem),
    .avail    (avail),
    .pop      (pop),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata)
  );

endmodule

`default_nettype wire

/* rtl/tsa_checker.sv */
// ============================================================================
// tsa_port_checks
// Port-level checks for the solid angle block.
// ============================================================================
`default_nettype none

module tsa_port_checks (
  input wire logic                      clk,
  input wire logic                      rst,
  input wire logic                      s_tvalid,
  input wire logic                      s_tready,
  input wire logic                      m_tvalid,
  input wire logic                      m_tready,
  input wire logic [tsa_pkg::OUT_W-1:0] m_tdata
);

  a_rst_empty: assert property (@(posedge clk) rst |=> !m_tvalid)
    else $error("result valid right after reset");

  a_rst_ready: assert property (@(posedge clk) rst |=> s_tready)
    else $error("not ready for requests after reset");

  a_out_known: assert property (@(posedge clk) disable iff (rst)
    m_tvalid |-> !$isunknown(m_tdata))
    else $error("unknown bits in result");

  a_hold: assert property (@(posedge clk) disable iff (rst)
    (m_tvalid && !m_tready) |=> (m_tvalid && $stable(m_tdata)))
    else $error("stalled result changed");

endmodule

bind triangle_solid_angle tsa_port_checks u_tsa_port_checks (
  .clk      (clk),
  .rst      (rst),
  .s_tvalid (s_tvalid),
  .s_tready (s_tready),
  .m_tvalid (m_tvalid),
  .m_tready (m_tready),
  .m_tdata  (m_tdata)
);

`default_nettype wire
